>>> sv/assert_macros.svh
// Assertion helpers for the text command motor drive.
// With SYNTH defined every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// A property checked at every rising edge outside reset.
`define TCMD_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An implication checked in the same cycle outside reset.
`define TCMD_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define TCMD_ASSERT(name, clk, rst, prop, msg)
`define TCMD_ASSERT_IMPL(name, clk, rst, ante, cons, msg)

`endif

`endif

>>> sv/tcmd_pkg.sv
package tcmd_pkg;

  // Line store sizes.
  localparam int KEPT_CHARS = 5;
  localparam logic [3:0] LENGTH_CAP = 4'd15;
  localparam logic [3:0] SPACES_CAP = 4'd15;

  // Reset values.
  localparam logic [7:0] SPEED_RESET = 8'd250;
  localparam logic [15:0] TIMEOUT_RESET = 16'd700;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_ONE = 8'h31;
  localparam logic [7:0] CH_TWO = 8'h32;
  localparam logic [7:0] CMD_SPEED = 8'h43;  // C
  localparam logic [7:0] CMD_ALL = 8'h47;    // G, shared speed target
  localparam logic [7:0] CMD_FWD = 8'h46;    // F
  localparam logic [7:0] CMD_BACK = 8'h42;   // B
  localparam logic [7:0] CMD_STOP = 8'h53;   // S
  localparam logic [7:0] CMD_UP = 8'h55;     // U
  localparam logic [7:0] CMD_DOWN = 8'h44;   // D
  localparam logic [7:0] CMD_LEFT = 8'h4C;   // L
  localparam logic [7:0] CMD_RIGHT = 8'h52;  // R
  localparam logic [7:0] CMD_SCREEN = 8'h58; // X

  // Input item kinds.
  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_CONNECT = 2'd2,
    OP_LOST    = 2'd3
  } opcode_t;

  // Result event codes.
  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_MOTION    = 4'd1,
    EV_SPEED_SET = 4'd2,
    EV_RANGE     = 4'd3,
    EV_MALFORMED = 4'd4,
    EV_UNKNOWN   = 4'd5,
    EV_TIMEOUT   = 4'd6,
    EV_LINK_STOP = 4'd7,
    EV_SCREEN    = 4'd8
  } event_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_SPEED_OFFSET = 1'b0,
    REG_IDLE_TIMEOUT = 1'b1
  } reg_index_t;

  // Trimmed line as gathered so far.
  typedef struct packed {
    logic [3:0] len;
    logic [KEPT_CHARS-1:0][7:0] chars;
  } line_t;

  // What a completed line asks of the drive.
  typedef struct packed {
    event_t ev;
    logic set_first;
    logic set_second;
    logic set_shared;
    logic [7:0] speed_val;
    logic first_we;
    logic [7:0] first_fwd;
    logic [7:0] first_rev;
    logic second_we;
    logic [7:0] second_fwd;
    logic [7:0] second_rev;
  } decode_t;

  // Whitespace other than newline.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) ||
           (c == 8'h0D);
  endfunction

endpackage

>>> sv/tcmd_line_buf.sv
module tcmd_line_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [7:0]     push_byte,
  input  logic           clear,
  output tcmd_pkg::line_t line
);
  import tcmd_pkg::*;

  logic [KEPT_CHARS-1:0][7:0] chars;
  logic [KEPT_CHARS-1:0][7:0] chars_next;
  logic [3:0] len;
  logic [3:0] len_next;
  logic [3:0] pending;
  logic [3:0] pending_next;
  logic [3:0] pend_eff;
  logic [4:0] char_pos;
  logic [4:0] len_sum;

  // Pending spaces are flushed only once the line has started.
  assign pend_eff = (len != 4'd0) ? pending : 4'd0;
  assign char_pos = {1'b0, len} + {1'b0, pend_eff};
  assign len_sum = char_pos + 5'd1;

  // A visible character writes its flushed spaces and itself in one go.
  always_comb begin
    chars_next = chars;
    len_next = len;
    pending_next = pending;
    if (clear) begin
      len_next = 4'd0;
      pending_next = 4'd0;
    end else if (push) begin
      if (is_ws(push_byte)) begin
        if ((len != 4'd0) && (pending < SPACES_CAP)) begin
          pending_next = pending + 4'd1;
        end
      end else begin
        for (int i = 0; i < KEPT_CHARS; i++) begin
          if ((5'(i) >= {1'b0, len}) && (5'(i) < char_pos)) begin
            chars_next[i] = CH_SPACE;
          end else if (5'(i) == char_pos) begin
            chars_next[i] = push_byte;
          end
        end
        len_next = (len_sum > {1'b0, LENGTH_CAP}) ? LENGTH_CAP : len_sum[3:0];
        pending_next = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= 4'd0;
      pending <= 4'd0;
    end else begin
      len <= len_next;
      pending <= pending_next;
    end
  end

  // Character store has no reset; only entries of the current line are read.
  always_ff @(posedge clk) begin
    chars <= chars_next;
  end

  assign line.len = len;
  assign line.chars = chars;

endmodule

>>> sv/tcmd_decode.sv
module tcmd_decode (
  input  tcmd_pkg::line_t   line,
  input  logic [7:0]        first_speed,
  input  logic [7:0]        second_speed,
  input  logic [7:0]        shared_speed,
  input  logic [8:0]        speed_offset,
  output tcmd_pkg::decode_t dec
);
  import tcmd_pkg::*;

  logic [KEPT_CHARS-1:0][7:0] ch;
  logic [7:0] c0;
  logic [7:0] c1;
  logic [9:0] mag;
  logic neg;
  logic in_digits;
  logic num_done;
  logic out_of_range;
  logic [7:0] first_own;
  logic [7:0] first_shared;

  // Offset and clamp for the first motor; a zero speed is left alone.
  function automatic logic [7:0] offset_speed(input logic [7:0] speed,
                                              input logic [8:0] offset);
    logic signed [9:0] sum;
    sum = $signed({2'b00, speed}) + $signed({offset[8], offset});
    if (speed == 8'd0) begin
      return 8'd0;
    end else if (sum < 10'sd0) begin
      return 8'd0;
    end else if (sum > 10'sd255) begin
      return 8'd255;
    end
    return sum[7:0];
  endfunction

  // Characters past the line length read as zero.
  always_comb begin
    for (int i = 0; i < KEPT_CHARS; i++) begin
      ch[i] = (4'(i) < line.len) ? line.chars[i] : 8'd0;
    end
  end

  assign c0 = ch[0];
  assign c1 = ch[1];

  // Number in characters three to five: blanks, optional sign, digits.
  always_comb begin
    mag = 10'd0;
    neg = 1'b0;
    in_digits = 1'b0;
    num_done = 1'b0;
    for (int k = 2; k < 5; k++) begin
      if (!in_digits) begin
        if (is_ws(ch[k])) begin
          // Still skipping leading blanks.
        end else if ((ch[k] == CH_PLUS) || (ch[k] == CH_MINUS)) begin
          neg = (ch[k] == CH_MINUS);
          in_digits = 1'b1;
        end else begin
          in_digits = 1'b1;
          if ((ch[k] >= CH_ZERO) && (ch[k] <= CH_NINE)) begin
            mag = (mag << 3) + (mag << 1) + {6'd0, ch[k][3:0]};
          end else begin
            num_done = 1'b1;
          end
        end
      end else if (!num_done) begin
        if ((ch[k] >= CH_ZERO) && (ch[k] <= CH_NINE)) begin
          mag = (mag << 3) + (mag << 1) + {6'd0, ch[k][3:0]};
        end else begin
          num_done = 1'b1;
        end
      end
    end
  end

  assign out_of_range = (neg && (mag != 10'd0)) || (mag > 10'd255);
  assign first_own = offset_speed(first_speed, speed_offset);
  assign first_shared = offset_speed(shared_speed, speed_offset);

  // Command decode of a completed line.
  always_comb begin
    dec = '0;
    dec.ev = EV_NONE;
    dec.speed_val = mag[7:0];
    if (line.len == 4'd0) begin
      dec.ev = EV_NONE;
    end else if (c0 == CMD_SPEED) begin
      if (line.len < 4'd5) begin
        dec.ev = EV_MALFORMED;
      end else if (out_of_range) begin
        dec.ev = EV_RANGE;
      end else if (c1 == CH_ONE) begin
        dec.set_first = 1'b1;
        dec.ev = EV_SPEED_SET;
      end else if (c1 == CH_TWO) begin
        dec.set_second = 1'b1;
        dec.ev = EV_SPEED_SET;
      end else if (c1 == CMD_ALL) begin
        dec.set_shared = 1'b1;
        dec.ev = EV_SPEED_SET;
      end else begin
        dec.ev = EV_UNKNOWN;
      end
    end else if ((c0 == CMD_FWD) || (c0 == CMD_BACK) || (c0 == CMD_STOP)) begin
      if (line.len == 4'd2) begin
        if (c1 == CH_ONE) begin
          dec.first_we = 1'b1;
          dec.first_fwd = (c0 == CMD_FWD) ? first_own : 8'd0;
          dec.first_rev = (c0 == CMD_BACK) ? first_own : 8'd0;
          dec.ev = EV_MOTION;
        end else if (c1 == CH_TWO) begin
          dec.second_we = 1'b1;
          dec.second_fwd = (c0 == CMD_FWD) ? second_speed : 8'd0;
          dec.second_rev = (c0 == CMD_BACK) ? second_speed : 8'd0;
          dec.ev = EV_MOTION;
        end else begin
          dec.ev = EV_MALFORMED;
        end
      end else if ((c0 == CMD_STOP) && (line.len == 4'd1)) begin
        dec.first_we = 1'b1;
        dec.second_we = 1'b1;
        dec.ev = EV_MOTION;
      end else begin
        dec.ev = EV_MALFORMED;
      end
    end else begin
      case (c0)
        CMD_UP: begin
          dec.first_we = 1'b1;
          dec.second_we = 1'b1;
          dec.first_fwd = first_shared;
          dec.second_fwd = shared_speed;
          dec.ev = EV_MOTION;
        end
        CMD_DOWN: begin
          dec.first_we = 1'b1;
          dec.second_we = 1'b1;
          dec.first_rev = first_shared;
          dec.second_rev = shared_speed;
          dec.ev = EV_MOTION;
        end
        CMD_LEFT: begin
          dec.first_we = 1'b1;
          dec.second_we = 1'b1;
          dec.first_rev = first_shared;
          dec.second_fwd = shared_speed;
          dec.ev = EV_MOTION;
        end
        CMD_RIGHT: begin
          dec.first_we = 1'b1;
          dec.second_we = 1'b1;
          dec.first_fwd = first_shared;
          dec.second_rev = shared_speed;
          dec.ev = EV_MOTION;
        end
        CMD_SCREEN: begin
          dec.ev = EV_SCREEN;
        end
        default: begin
          dec.ev = EV_UNKNOWN;
        end
      endcase
    end
  end

endmodule

>>> sv/text_command_dual_motor_drive_unit.sv
// Text command drive for two H-bridge motors. Each input transaction carries one
// event in s_tuser (byte, millisecond tick, link up, link down) and, for bytes, the
// character in s_tdata. Every input transaction yields exactly one output
// transaction holding the four duty values and an event code. One transaction is
// taken every clock cycle while the output side keeps up; a result passes an input
// register and then the result register that the line store, timer and speed
// registers update with. A stalled output holds both stages. There is no clearing
// pass after reset, and configuration writes are taken in any cycle.
module text_command_dual_motor_drive_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // first_fwd_duty[7:0], first_rev_duty[15:8], second_fwd_duty[23:16],
  // second_rev_duty[31:24], event_code[35:32], zero fill[39:36]
  output logic [39:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import tcmd_pkg::*;

  `include "assert_macros.svh"

  logic in_valid;
  opcode_t in_op;
  logic [7:0] in_byte;
  logic advance;
  logic work;

  logic [8:0] speed_offset;
  logic [15:0] idle_timeout;
  logic [7:0] first_speed;
  logic [7:0] second_speed;
  logic [7:0] shared_speed;
  logic [3:0][7:0] duty;
  logic [3:0][7:0] duty_next;
  logic [15:0] idle_ms;
  logic [15:0] idle_ms_next;
  logic [16:0] idle_inc;
  logic link_up;
  logic link_up_next;
  event_t ev_next;
  event_t out_event;

  logic line_push;
  logic line_clear;
  logic line_end;
  line_t line;
  decode_t dec;

  // Stage handshake: the result register frees up when taken.
  assign advance = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign work = in_valid && advance;
  assign cfg_ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_op <= opcode_t'(s_tuser);
      in_byte <= s_tdata;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_offset <= 9'd0;
      idle_timeout <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_SPEED_OFFSET: speed_offset <= cfg_data[8:0];
        REG_IDLE_TIMEOUT: idle_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  assign line_end = work && (in_op == OP_BYTE) && link_up && (in_byte == CH_NEWLINE);
  assign line_push = work && (in_op == OP_BYTE) && link_up && (in_byte != CH_NEWLINE);
  assign line_clear = line_end ||
                      (work && (in_op == OP_CONNECT) && !link_up) ||
                      (work && (in_op == OP_LOST) && link_up);

  tcmd_line_buf u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (line_push),
    .push_byte (in_byte),
    .clear     (line_clear),
    .line      (line)
  );

  tcmd_decode u_decode (
    .line         (line),
    .first_speed  (first_speed),
    .second_speed (second_speed),
    .shared_speed (shared_speed),
    .speed_offset (speed_offset),
    .dec          (dec)
  );

  assign idle_inc = {1'b0, idle_ms} + 17'd1;

  // Event handling for the item in the input register.
  always_comb begin
    duty_next = duty;
    idle_ms_next = idle_ms;
    link_up_next = link_up;
    ev_next = EV_NONE;
    case (in_op)
      OP_BYTE: begin
        if (line_end) begin
          idle_ms_next = 16'd0;
          ev_next = dec.ev;
          if (dec.first_we) begin
            duty_next[0] = dec.first_fwd;
            duty_next[1] = dec.first_rev;
          end
          if (dec.second_we) begin
            duty_next[2] = dec.second_fwd;
            duty_next[3] = dec.second_rev;
          end
        end
      end
      OP_TICK: begin
        if (link_up) begin
          if (idle_inc > {1'b0, idle_timeout}) begin
            duty_next = '0;
            idle_ms_next = 16'd0;
            ev_next = EV_TIMEOUT;
          end else begin
            idle_ms_next = idle_inc[15:0];
          end
        end
      end
      OP_CONNECT: begin
        if (!link_up) begin
          link_up_next = 1'b1;
          idle_ms_next = 16'd0;
        end
      end
      OP_LOST: begin
        if (link_up) begin
          link_up_next = 1'b0;
          duty_next = '0;
          ev_next = EV_LINK_STOP;
        end
      end
      default: ;
    endcase
  end

  // Drive state and result register; the duty registers double as result data.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      duty <= '0;
      idle_ms <= 16'd0;
      link_up <= 1'b0;
      first_speed <= SPEED_RESET;
      second_speed <= SPEED_RESET;
      shared_speed <= SPEED_RESET;
      out_event <= EV_NONE;
    end else if (advance) begin
      m_tvalid <= in_valid;
      if (in_valid) begin
        duty <= duty_next;
        idle_ms <= idle_ms_next;
        link_up <= link_up_next;
        out_event <= ev_next;
        if (line_end && dec.set_first) begin
          first_speed <= dec.speed_val;
        end
        if (line_end && dec.set_second) begin
          second_speed <= dec.speed_val;
        end
        if (line_end && dec.set_shared) begin
          shared_speed <= dec.speed_val;
        end
      end
    end
  end

  assign m_tdata = {4'd0, out_event, duty[3], duty[2], duty[1], duty[0]};

  // Checks on the drive state.
  `TCMD_ASSERT_IMPL(a_link_down_idle, clk, rst, !link_up, duty == '0, "motors run while link down")
  `TCMD_ASSERT_IMPL(a_stop_event_zero, clk, rst, m_tvalid && ((out_event == EV_TIMEOUT) || (out_event == EV_LINK_STOP)), duty == '0, "stop event with nonzero duty")
  `TCMD_ASSERT(a_stall_cause, clk, rst, s_tready || (in_valid && m_tvalid && !m_tready), "input stalled without cause")

endmodule
